>>> hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared wrappers for concurrent assertions, clocked on clk_i and
// disabled while rst_ni is low
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a implies c in the same cycle
`define ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (c)) \
    else $error("assertion failed");

// a implies c in the next cycle
`define ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (c)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/eaf_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// eaf_pkg
// types and constants of the encoder angle filter
// ---------------------------------------------------------------------------
package eaf_pkg;

  localparam int PosW    = 12;
  localparam int RawW    = 16;
  localparam int AlphaW  = 9;
  localparam int AngleW  = 18;
  localparam int CfgW    = 12;
  localparam int CfgIdxW = 1;

  localparam int RingDepthDefault = 8;

  localparam logic [AlphaW-1:0] AlphaFull    = 9'd256;
  localparam logic [AlphaW-1:0] AlphaReset   = 9'd128;
  localparam logic [PosW-1:0]   HomeReset    = 12'd0;
  localparam logic [PosW-1:0]   PosInvalid   = 12'hFFF;
  localparam logic [PosW-1:0]   PosZero      = 12'd0;
  localparam logic [5:0]        FinePerCount = 6'd45;

  // request codes
  localparam logic ReqFrame = 1'b0;
  localparam logic ReqTick  = 1'b1;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgAlpha = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgHome  = 1'b1;

  typedef struct packed {
    logic            req_type;
    logic [RawW-1:0] raw_word;
  } eaf_in_t;

  typedef struct packed {
    logic [PosW-1:0]   position;
    logic [AngleW-1:0] angle_fine;
  } eaf_out_t;

  // frame write toward the sample ring
  typedef struct packed {
    logic            wr;
    logic [PosW-1:0] pos;
  } eaf_frame_t;

endpackage

>>> hw/rtl/eaf_ring.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// eaf_ring
// blends a new position with the last stored sample, keeps the last
// RING_DEPTH samples in a shift line and a running sum over them
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module eaf_ring import eaf_pkg::*; #(
  parameter int RING_DEPTH = RingDepthDefault,
  localparam int SumW = PosW + $clog2(RING_DEPTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  eaf_frame_t        frame_i,
  input  logic [AlphaW-1:0] alpha_i,
  output logic [SumW-1:0]   sum_o
);

  logic [PosW-1:0]   taps_q [RING_DEPTH];
  logic [SumW-1:0]   sum_q, sum_d;
  logic [AlphaW-1:0] wgt_prev, wgt_new;
  logic [20:0]       mix;
  logic [PosW-1:0]   blend;
  logic [PosW-1:0]   prev;

  assign prev = taps_q[0];

  always_comb begin
    wgt_prev = (alpha_i > AlphaFull) ? AlphaFull : alpha_i;
    wgt_new  = AlphaFull - wgt_prev;
    mix      = 21'(wgt_new) * 21'(frame_i.pos) + 21'(wgt_prev) * 21'(prev);
    blend    = mix[PosW+7:8];
    // oldest sample drops out as the new one enters
    sum_d    = sum_q + SumW'(blend) - SumW'(taps_q[RING_DEPTH-1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      for (int i = 0; i < RING_DEPTH; i++) begin
        taps_q[i] <= '0;
      end
    end else if (frame_i.wr) begin
      sum_q     <= sum_d;
      taps_q[0] <= blend;
      for (int i = 1; i < RING_DEPTH; i++) begin
        taps_q[i] <= taps_q[i-1];
      end
    end
  end

  assign sum_o = sum_q;

  `ASSERT_NEXT(a_sum_hold, !frame_i.wr, $stable(sum_q))
  `ASSERT_IMPL(a_blend_range, frame_i.wr,
               (blend <= frame_i.pos || blend <= prev) &&
               (blend >= frame_i.pos || blend >= prev))

endmodule

>>> hw/rtl/eaf_mean.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// eaf_mean
// ring mean by reciprocal multiply, home offset and angle scaling,
// with a product stage and the result register
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module eaf_mean import eaf_pkg::*; #(
  parameter int RING_DEPTH = RingDepthDefault,
  localparam int SumW = PosW + $clog2(RING_DEPTH)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            tick_push_i,
  output logic            tick_ready_o,
  input  logic [SumW-1:0] sum_i,
  input  logic [PosW-1:0] home_offset_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output eaf_out_t        out_data_o
);

  localparam int CntW       = $clog2(RING_DEPTH);
  localparam int RecipShift = SumW + CntW;
  localparam int RecipW     = SumW + 1;
  localparam int ProdW      = SumW + RecipW;
  localparam logic [RecipW-1:0] Recip =
    RecipW'(((longint'(1) << RecipShift) + longint'(RING_DEPTH) - 1) / RING_DEPTH);

  logic              mid_valid_q;
  logic [PosW-1:0]   mean_q;
  logic              out_valid_q;
  eaf_out_t          out_q;
  logic              out_free;
  logic [ProdW-1:0]  prod;
  logic [PosW-1:0]   rel;
  logic [AngleW-1:0] rel_x;
  logic [AngleW-1:0] angle;

  assign out_free     = !out_valid_q || out_ready_i;
  assign tick_ready_o = !mid_valid_q || out_free;

  // exact floor division by the ring depth over the whole sum range
  assign prod = ProdW'(sum_i) * ProdW'(Recip);

  always_comb begin
    rel   = mean_q - home_offset_i;
    rel_x = AngleW'(rel);
    // times 45 as shift and add
    angle = (rel_x << 5) + (rel_x << 3) + (rel_x << 2) + rel_x;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
    end else if (tick_push_i) begin
      mid_valid_q <= 1'b1;
    end else if (out_free) begin
      mid_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_push_i) begin
      mean_q <= prod[RecipShift +: PosW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= mid_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && mid_valid_q) begin
      out_q.position   <= rel;
      out_q.angle_fine <= angle;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_IMPL(a_angle_scale, out_valid_q,
               out_q.angle_fine == AngleW'(out_q.position) * AngleW'(FinePerCount))

endmodule

>>> hw/rtl/encoder_angle_filter.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// encoder_angle_filter
// spike filter, moving average and home-relative angle for a 12-bit encoder
// ---------------------------------------------------------------------------
// Takes one item per clock cycle while no tick waits on the mean stage. An
// encoder frame updates the sample ring at the clock edge after it is
// accepted and gives no result; positions 0 and 4095 are dropped. A tick
// sees every frame accepted before it. Its result is registered in the mean
// register, then in the result register; an output stall can hold it at
// either step. The ring mean comes from a running sum kept beside a shift
// line of RING_DEPTH samples, so a tick costs one reciprocal multiply,
// whatever the depth. Write alpha and home_offset only while no item is in
// flight.

module encoder_angle_filter import eaf_pkg::*; #(
  parameter int RING_DEPTH = RingDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  eaf_in_t            in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output eaf_out_t           out_data_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i
);

  localparam int SumW = PosW + $clog2(RING_DEPTH);

  logic              in_valid_q;
  eaf_in_t           in_q;
  logic [AlphaW-1:0] alpha_q;
  logic [PosW-1:0]   home_q;
  logic              tick_ready;
  logic              tick_push;
  logic              advance;
  logic [PosW-1:0]   pos;
  eaf_frame_t        frame;
  logic [SumW-1:0]   sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= AlphaReset;
      home_q  <= HomeReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgAlpha: alpha_q <= cfg_wdata_i[AlphaW-1:0];
        CfgHome:  home_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // frames always leave the input register, ticks wait for the mean stage
  assign advance    = in_valid_q && (in_q.req_type == ReqFrame || tick_ready);
  assign tick_push  = in_valid_q && in_q.req_type == ReqTick && tick_ready;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  assign pos       = in_q.raw_word[PosW:1];
  assign frame.pos = pos;
  assign frame.wr  = in_valid_q && in_q.req_type == ReqFrame &&
                     pos != PosZero && pos != PosInvalid;

  eaf_ring #(
    .RING_DEPTH(RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .frame_i (frame),
    .alpha_i (alpha_q),
    .sum_o   (sum)
  );

  eaf_mean #(
    .RING_DEPTH(RING_DEPTH)
  ) u_mean (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tick_push_i   (tick_push),
    .tick_ready_o  (tick_ready),
    .sum_i         (sum),
    .home_offset_i (home_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_o    (out_data_o)
  );

  `ASSERT_IMPL(a_stall_on_tick, !in_ready_o,
               in_valid_q && in_q.req_type == ReqTick)

endmodule

>>> test/tb_encoder_angle_filter.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_encoder_angle_filter
// self-checking testbench for the encoder angle filter: a behavioral copy
// of the blend, the sample ring and the tick math predicts every angle,
// which is compared field by field with the block's result transfers under
// random sender bursts, receiver stalls and several alpha/home settings
// ---------------------------------------------------------------------------
module tb_encoder_angle_filter;
  import eaf_pkg::*;

  localparam int Depth         = RingDepthDefault;
  localparam int SettleCycles  = 8;
  localparam int LongHold      = 80;
  localparam int DrainLimit    = 2000;
  localparam int CycleLimit    = 200000;
  localparam int RandomPhases  = 7;
  localparam int PhaseItems    = 100;
  localparam int FineFactor    = 45;

  typedef enum logic [1:0] {
    ReadyAlways,
    ReadyHalf,
    ReadySparse,
    ReadyPeriodic
  } stall_mode_e;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  eaf_in_t            in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  eaf_out_t           out_data;
  logic               cfg_we    = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx   = CfgAlpha;
  logic [CfgW-1:0]    cfg_wdata = '0;

  eaf_in_t  pending_requests[$];
  eaf_out_t expected_angles[$];

  // behavioral copy of the filter state and its registers
  logic [PosW-1:0]   ring_model [Depth];
  int unsigned       ring_ptr    = 0;
  logic [AlphaW-1:0] alpha_model = AlphaReset;
  logic [PosW-1:0]   home_model  = HomeReset;

  int unsigned errors         = 0;
  int unsigned frames_seen    = 0;
  int unsigned frames_dropped = 0;
  int unsigned ticks_seen     = 0;
  int unsigned results_seen   = 0;
  int unsigned reg_writes     = 0;
  int unsigned cycle_count    = 0;

  int unsigned long_hold_reqs   = 0;
  int unsigned long_hold_served = 0;

  int unsigned burst_left  = 1;
  int unsigned gap_left    = 0;
  int unsigned hold_left   = 0;
  int unsigned mode_left   = 0;
  int unsigned pattern_cnt = 0;
  stall_mode_e stall_mode  = ReadyAlways;

  encoder_angle_filter u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    errors++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // blend a frame into the ring; spike positions leave everything alone
  function automatic void apply_frame(input logic [RawW-1:0] raw);
    logic [PosW-1:0] pos;
    int unsigned     weight;
    int unsigned     blend;
    pos = raw[PosW:1];
    if (pos == PosZero || pos == PosInvalid) begin
      frames_dropped++;
      return;
    end
    weight = (alpha_model > AlphaFull) ? int'(AlphaFull) : int'(alpha_model);
    blend = ((int'(AlphaFull) - weight) * int'(pos) + weight * int'(ring_model[ring_ptr])) >> 8;
    ring_ptr = (ring_ptr + 1) % Depth;
    ring_model[ring_ptr] = blend[PosW-1:0];
  endfunction

  function automatic eaf_out_t predict_angle();
    int unsigned     sum;
    logic [PosW-1:0] mean;
    logic [PosW-1:0] rel;
    eaf_out_t        res;
    sum = 0;
    for (int i = 0; i < Depth; i++) sum += ring_model[i];
    mean = PosW'(sum / Depth);
    rel = mean - home_model;
    res.position = rel;
    res.angle_fine = AngleW'(int'(rel) * FineFactor);
    return res;
  endfunction

  task automatic push_frame(input logic [PosW-1:0] pos);
    eaf_in_t req;
    req.req_type = ReqFrame;
    req.raw_word = RawW'($urandom);
    req.raw_word[PosW:1] = pos;
    pending_requests.push_back(req);
  endtask

  task automatic push_tick();
    eaf_in_t req;
    req.req_type = ReqTick;
    req.raw_word = RawW'($urandom);
    pending_requests.push_back(req);
  endtask

  function automatic eaf_in_t random_request(input int unsigned tick_pct);
    eaf_in_t req;
    req.req_type = ($urandom_range(0, 99) < tick_pct) ? ReqTick : ReqFrame;
    req.raw_word = RawW'($urandom);
    // now and then land on the spike codes or the edges of the valid range
    if ($urandom_range(0, 15) == 0) begin
      case ($urandom_range(0, 3))
        0:       req.raw_word[PosW:1] = PosZero;
        1:       req.raw_word[PosW:1] = PosInvalid;
        2:       req.raw_word[PosW:1] = 12'd1;
        default: req.raw_word[PosW:1] = 12'd4094;
      endcase
    end
    return req;
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= CfgW'(value);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // nothing queued, nothing offered, nothing owed, pipeline settled
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_angles.size() != 0);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // sender: bursts of random length with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0 || pending_requests.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_data  <= pending_requests.pop_front();
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) :
                                                    $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // receiver: stall pattern that switches to a random mode at random intervals
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (long_hold_served < long_hold_reqs) begin
      long_hold_served++;
      hold_left = LongHold;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        mode_left  = $urandom_range(20, 120);
      end else begin
        mode_left--;
      end
      pattern_cnt++;
      case (stall_mode)
        ReadyAlways: out_ready <= 1'b1;
        ReadyHalf:   out_ready <= 1'($urandom_range(0, 1));
        ReadySparse: out_ready <= ($urandom_range(0, 3) == 0);
        default:     out_ready <= ((pattern_cnt % 5) < 3);
      endcase
    end
  end

  // track register writes and input transfers, check result transfers
  always @(posedge clk) begin : check_proc
    eaf_out_t want;
    if (rst_n) begin
      if (cfg_we) begin
        reg_writes++;
        if (cfg_idx == CfgAlpha) alpha_model = cfg_wdata[AlphaW-1:0];
        else                     home_model  = cfg_wdata[PosW-1:0];
      end
      if (in_valid && in_ready) begin
        if (in_data.req_type == ReqTick) begin
          ticks_seen++;
          expected_angles.push_back(predict_angle());
        end else begin
          frames_seen++;
          apply_frame(in_data.raw_word);
        end
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_angles.size() == 0) begin
          report_mismatch($sformatf("result pos=%0d angle=%0d with nothing expected",
                                    out_data.position, out_data.angle_fine));
        end else begin
          want = expected_angles.pop_front();
          if (out_data.position !== want.position)
            report_mismatch($sformatf("position got %0d want %0d",
                                      out_data.position, want.position));
          if (out_data.angle_fine !== want.angle_fine)
            report_mismatch($sformatf("angle_fine got %0d want %0d",
                                      out_data.angle_fine, want.angle_fine));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("cycle limit of %0d reached, %0d results still owed",
               CycleLimit, expected_angles.size());
      $display("[encoder_angle_filter] ERROR");
      $finish;
    end
  end

  initial begin : stimulus_proc
    int unsigned alpha_val;
    int unsigned home_val;
    int unsigned tick_pct;
    int unsigned drain_wait;
    eaf_out_t    missing;

    for (int i = 0; i < Depth; i++) ring_model[i] = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // reset values: empty ring, spike frames, valid range edges, pointer wrap
    push_tick();
    push_frame(PosZero);
    push_frame(PosInvalid);
    push_tick();
    push_frame(12'd1);
    push_frame(12'd4094);
    push_tick();
    for (int i = 0; i < Depth + 2; i++) push_frame(12'd4094);
    push_tick();
    wait_idle();

    // no smoothing, home at the top so the relative position wraps
    write_reg(CfgAlpha, 0);
    write_reg(CfgHome, 4095);
    push_frame(12'd1);
    push_frame(12'd2047);
    push_tick();
    wait_idle();

    // full weight on the previous sample, then weights that saturate
    write_reg(CfgAlpha, 256);
    write_reg(CfgHome, 0);
    push_frame(12'd2000);
    push_tick();
    wait_idle();
    write_reg(CfgAlpha, 511);
    push_frame(12'd3000);
    push_tick();
    wait_idle();

    for (int p = 0; p < RandomPhases; p++) begin
      case ($urandom_range(0, 5))
        0:       alpha_val = 0;
        1:       alpha_val = 256;
        2:       alpha_val = 511;
        3:       alpha_val = $urandom_range(257, 511);
        default: alpha_val = $urandom_range(0, 256);
      endcase
      case ($urandom_range(0, 3))
        0:       home_val = 0;
        1:       home_val = 4095;
        default: home_val = $urandom_range(0, 4095);
      endcase
      // upper write-data bits beyond the alpha field must be ignored
      write_reg(CfgAlpha, alpha_val | ($urandom_range(0, 7) << AlphaW));
      write_reg(CfgHome, home_val);
      tick_pct = 30;
      if (p == 2) begin
        // receiver goes quiet while the sender keeps offering
        long_hold_reqs++;
        tick_pct = 50;
      end
      if (p == 4) begin
        for (int i = 0; i < PhaseItems / 2; i++)
          pending_requests.push_back(random_request(tick_pct));
        wait_idle();
        for (int i = 0; i < PhaseItems / 2; i++)
          pending_requests.push_back(random_request(tick_pct));
      end else begin
        for (int i = 0; i < PhaseItems; i++)
          pending_requests.push_back(random_request(tick_pct));
      end
      wait_idle();
    end

    do @(negedge clk);
    while (pending_requests.size() != 0 || in_valid);
    drain_wait = 0;
    while (expected_angles.size() != 0 && drain_wait < DrainLimit) begin
      @(negedge clk);
      drain_wait++;
    end
    repeat (SettleCycles) @(negedge clk);
    while (expected_angles.size() != 0) begin
      missing = expected_angles.pop_front();
      report_mismatch($sformatf("result pos=%0d angle=%0d never arrived",
                                missing.position, missing.angle_fine));
    end

    $display("covered %0d frames (%0d spikes dropped) and %0d ticks, %0d results checked",
             frames_seen, frames_dropped, ticks_seen, results_seen);
    $display("%0d register writes over %0d settings, %0d mismatches",
             reg_writes, RandomPhases + 4, errors);
    if (errors == 0) begin
      $display("[encoder_angle_filter] OK");
    end else begin
      $display("[encoder_angle_filter] ERROR");
    end
    $finish;
  end

endmodule
